@@ src/mva_pkg.sv @@
// mva_pkg: shared types, codes and constants of the matrix-vector multiply-add block
// no dependencies; imported by matrix_vector_multiply_add
package mva_pkg;

  localparam int VALUE_BITS       = 16;
  localparam int FRAC_BITS        = 12;
  localparam int ROW_W            = 6;
  localparam int COL_W            = 6;
  localparam int CFG_W            = 7;
  localparam int APB_DATA_W       = 32;
  localparam int APB_ADDR_W       = 3;
  localparam int DEFAULT_MAX_ROWS = 64;
  localparam int DEFAULT_MAX_COLS = 64;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // register index, taken from the word address
  localparam logic REG_ROWS_IN_USE = 1'b0;
  localparam logic REG_COLS_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    ACT_LOAD_WEIGHT = 2'd0,
    ACT_LOAD_BIAS   = 2'd1,
    ACT_LOAD_INPUT  = 2'd2,
    ACT_COMPUTE     = 2'd3
  } action_e;

  typedef struct packed {
    action_e                       action;
    logic [ROW_W-1:0]              row;
    logic [COL_W-1:0]              col;
    logic signed [VALUE_BITS-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]              out_row;
    logic signed [VALUE_BITS-1:0]  out_value;
    logic                          saturated;
    logic                          last;
  } out_item_t;

endpackage

@@ src/matrix_vector_multiply_add.sv @@
// matrix_vector_multiply_add: dense layer y = W*x + b with weight, bias and input memories
// depends on mva_pkg (types, action codes, register indexes, widths)
//
// usage
//   input channel (in_valid_i / in_stall_o / in_data_i): one transaction either loads a
//   weight word at (row, col), a bias word at row, an input-vector word at col, or starts
//   a compute. loads with a row >= MAX_ROWS or a col >= MAX_COLS are dropped.
//   output channel (out_valid_o / out_stall_i / out_data_o): a compute gives one
//   transaction per row in use, rows in ascending order, last set on the final row.
//   apb port: rows_in_use at byte 0, cols_in_use at byte 4, 7 bits each; 0 acts as 1
//   and values above the maximum act as the maximum. write only while idle.
// timing
//   loads: one per cycle while idle, written into the memories at the accepting edge.
//   compute: one weight/input read per cycle while the output is not stalled, row by row;
//   a row appears once its last column is accumulated, and the next transaction is taken
//   once the final row enters the output register. stages: read, multiply, accumulate, output.
// stalls and reset
//   a stalled output freezes the whole pipeline and the sequencer;
//   the next transaction is taken while the final row still waits in the output register.
//   reset clears control state and sets both registers to 64; memories undefined until written.
module matrix_vector_multiply_add #(
  parameter int MAX_ROWS = mva_pkg::DEFAULT_MAX_ROWS,
  parameter int MAX_COLS = mva_pkg::DEFAULT_MAX_COLS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input transactions
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  mva_pkg::in_item_t                   in_data_i,
  // output transactions
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output mva_pkg::out_item_t                  out_data_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mva_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [mva_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [mva_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);
  import mva_pkg::*;

  localparam int VB     = VALUE_BITS;
  localparam int RA_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CA_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int W_DEPTH = MAX_ROWS * (2 ** CA_W);
  localparam int ACC_W  = 2 * VB + FRAC_BITS + $clog2(MAX_COLS + 2) + 1;
  localparam int TOP_W  = ACC_W - FRAC_BITS - VB + 1;

  typedef struct packed {
    logic [RA_W-1:0] row;
    logic            first_col;
    logic            last_col;
    logic            last_row;
  } tag_t;

  // configuration registers
  logic [CFG_W-1:0] rows_cfg_q, cols_cfg_q;
  logic             cfg_wr;

  // control
  logic             busy_q, run_q;
  logic [RA_W-1:0]  r_q, rows_last_q, rows_last_d;
  logic [CA_W-1:0]  c_q, cols_last_q, cols_last_d;
  logic             in_acc, adv, issue;

  // memories and their registered read data
  logic signed [VB-1:0] w_mem [W_DEPTH];
  logic signed [VB-1:0] b_mem [MAX_ROWS];
  logic signed [VB-1:0] x_mem [MAX_COLS];
  logic signed [VB-1:0] w_rd_q, x_rd_q, b_rd_q;

  // pipeline
  logic                    s1_vld_q, s2_vld_q, s3_vld_q;
  tag_t                    s1_tag_q, s2_tag_q, s3_tag_q;
  logic signed [2*VB-1:0]  prod_q;
  logic signed [VB-1:0]    bias_q;
  logic signed [ACC_W-1:0] acc_q, acc_base, acc_d;

  // rounding and saturation
  logic [TOP_W-1:0]        acc_top;
  logic                    sat;
  logic signed [VB-1:0]    res;

  // output register
  logic                    out_valid_q;
  out_item_t               out_q;

  //--------------------------------------------------------------------------
  // apb register file, always ready
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= CFG_RESET;
      cols_cfg_q <= CFG_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_ROWS_IN_USE: rows_cfg_q <= pwdata[CFG_W-1:0];
        REG_COLS_IN_USE: cols_cfg_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROWS_IN_USE: prdata = APB_DATA_W'(rows_cfg_q);
      REG_COLS_IN_USE: prdata = APB_DATA_W'(cols_cfg_q);
      default:         prdata = '0;
    endcase
  end

  // clamp register values to the last row / column index of a compute
  always_comb begin
    int rows_eff;
    int cols_eff;
    rows_eff = (rows_cfg_q == '0) ? 1 :
               ((int'(rows_cfg_q) > MAX_ROWS) ? MAX_ROWS : int'(rows_cfg_q));
    cols_eff = (cols_cfg_q == '0) ? 1 :
               ((int'(cols_cfg_q) > MAX_COLS) ? MAX_COLS : int'(cols_cfg_q));
    rows_last_d = RA_W'(rows_eff - 1);
    cols_last_d = CA_W'(cols_eff - 1);
  end

  //--------------------------------------------------------------------------
  // handshakes: input blocked for the whole compute, pipeline frozen on a held result
  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;
  assign adv        = !out_valid_q || !out_stall_i;
  assign issue      = run_q && adv;

  // sequencer: walks columns inside rows, one read per advancing cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      run_q       <= 1'b0;
      r_q         <= '0;
      c_q         <= '0;
      rows_last_q <= '0;
      cols_last_q <= '0;
    end else begin
      if (in_acc && in_data_i.action == ACT_COMPUTE) begin
        busy_q      <= 1'b1;
        run_q       <= 1'b1;
        r_q         <= '0;
        c_q         <= '0;
        rows_last_q <= rows_last_d;
        cols_last_q <= cols_last_d;
      end else begin
        if (issue) begin
          if (c_q == cols_last_q) begin
            c_q <= '0;
            if (r_q == rows_last_q) begin
              run_q <= 1'b0;
            end else begin
              r_q <= r_q + RA_W'(1);
            end
          end else begin
            c_q <= c_q + CA_W'(1);
          end
        end
        // final row handed to the output register ends the compute
        if (adv && s3_vld_q && s3_tag_q.last_col && s3_tag_q.last_row) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  //--------------------------------------------------------------------------
  // memories: loads write while idle, compute reads through a read data register
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      case (in_data_i.action)
        ACT_LOAD_WEIGHT: begin
          if (32'(in_data_i.row) < MAX_ROWS && 32'(in_data_i.col) < MAX_COLS) begin
            w_mem[{RA_W'(in_data_i.row), CA_W'(in_data_i.col)}] <= in_data_i.value;
          end
        end
        default: ;
      endcase
    end
    if (issue) begin
      w_rd_q <= w_mem[{r_q, c_q}];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.action == ACT_LOAD_BIAS && 32'(in_data_i.row) < MAX_ROWS) begin
      b_mem[RA_W'(in_data_i.row)] <= in_data_i.value;
    end
    if (issue) begin
      b_rd_q <= b_mem[r_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_data_i.action == ACT_LOAD_INPUT && 32'(in_data_i.col) < MAX_COLS) begin
      x_mem[CA_W'(in_data_i.col)] <= in_data_i.value;
    end
    if (issue) begin
      x_rd_q <= x_mem[c_q];
    end
  end

  //--------------------------------------------------------------------------
  // pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q    <= run_q;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      out_valid_q <= s3_vld_q && s3_tag_q.last_col;
    end
  end

  // accumulator seed: bias scaled by 2^frac plus half an lsb for rounding
  assign acc_base = s2_tag_q.first_col
                  ? {{(ACC_W - VB - FRAC_BITS){bias_q[VB-1]}}, bias_q,
                     1'b1, {(FRAC_BITS - 1){1'b0}}}
                  : acc_q;
  assign acc_d    = acc_base + {{(ACC_W - 2 * VB){prod_q[2*VB-1]}}, prod_q};

  // round to nearest already folded in; keep bits above the fraction and clip
  assign acc_top = acc_q[ACC_W-1:FRAC_BITS+VB-1];
  assign sat     = !((&acc_top) || !(|acc_top));
  always_comb begin
    if (!sat) begin
      res = acc_q[FRAC_BITS+VB-1:FRAC_BITS];
    end else if (acc_q[ACC_W-1]) begin
      res = {1'b1, {(VB - 1){1'b0}}};
    end else begin
      res = {1'b0, {(VB - 1){1'b1}}};
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_tag_q.row       <= r_q;
      s1_tag_q.first_col <= (c_q == '0);
      s1_tag_q.last_col  <= (c_q == cols_last_q);
      s1_tag_q.last_row  <= (r_q == rows_last_q);
      s2_tag_q           <= s1_tag_q;
      s3_tag_q           <= s2_tag_q;
      prod_q             <= w_rd_q * x_rd_q;
      bias_q             <= b_rd_q;
      if (s2_vld_q) begin
        acc_q <= acc_d;
      end
      out_q.out_row      <= ROW_W'(s3_tag_q.row);
      out_q.out_value    <= res;
      out_q.saturated    <= sat;
      out_q.last         <= s3_tag_q.last_row;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  //--------------------------------------------------------------------------
  // checks
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> !run_q && !s1_vld_q && !s2_vld_q && !s3_vld_q)
    else $error("pipeline holds work while idle");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> busy_q)
    else $error("sequencer running outside a compute");

  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (r_q <= rows_last_q) && (c_q <= cols_last_q))
    else $error("sequencer index beyond rows or columns in use");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s3_vld_q && s3_tag_q.last_col && s3_tag_q.last_row |=> !busy_q && out_valid_q)
    else $error("final row did not end the compute");

endmodule
